[src/s2x_pkg.sv]
// Shared constants and types for the Scale2x upscaler.
package s2x_pkg;

   localparam int PIX_W   = 16;
   localparam int COORD_W = 8;
   localparam int CSR_W   = 8;

   localparam int DEF_LINE_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT  = 240;
   localparam int DEF_QUEUE_DEPTH = 4;
   localparam logic [CSR_W-1:0] DEF_FRAME_HEIGHT = 8'd224;

   // window rows: two lines back, one line back, current line
   localparam int ROW_TOP = 0;
   localparam int ROW_MID = 1;
   localparam int ROW_BOT = 2;
   // window columns: two back, one back, current
   localparam int COL_PREV2 = 0;
   localparam int COL_PREV  = 1;
   localparam int COL_CUR   = 2;

   // result slots of one transaction, in output order
   localparam int SUB_ABOVE_PREV = 0;
   localparam int SUB_ABOVE_LAST = 1;
   localparam int SUB_HERE_PREV  = 2;
   localparam int SUB_HERE_LAST  = 3;
   localparam int SUB_N          = 4;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [2:0][PIX_W-1:0] column_type;

   typedef struct packed {
      logic [2:0][2:0][PIX_W-1:0] win;
      logic [COORD_W-1:0]         row;
      logic [COORD_W-1:0]         col;
      logic                       row_ge1;
      logic                       row_ge2;
      logic                       col_ge2;
      logic [SUB_N-1:0]           mask;
   } s2x_entry_type;

endpackage

[src/s2x_if.sv]
// Handshake channel interfaces for source pixels and output blocks.
interface s2x_req_if;
   import s2x_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             frame_start;
   modport source (output valid, pixel, frame_start, input ready);
   modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface s2x_rsp_if;
   import s2x_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   top_left;
   logic [PIX_W-1:0]   top_right;
   logic [PIX_W-1:0]   bottom_left;
   logic [PIX_W-1:0]   bottom_right;
   logic [COORD_W-1:0] src_column;
   logic [COORD_W-1:0] src_row;
   logic               run_last;
   modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                   src_column, src_row, run_last, input ready);
   modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                   src_column, src_row, run_last, output ready);
endinterface

[src/s2x_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module s2x_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[src/s2x_front.sv]
// Front end: accepts pixels, tracks position, reads line store, builds 3x3 window.
module s2x_front #(
   parameter int LINE_WIDTH = s2x_pkg::DEF_LINE_WIDTH,
   parameter int MAX_HEIGHT = s2x_pkg::DEF_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [s2x_pkg::CSR_W-1:0]  csr_wr_data,
   s2x_req_if.sink                    req,
   input  logic                       q_full,
   output logic                       q_push,
   output s2x_pkg::s2x_entry_type     q_data
);
   import s2x_pkg::*;

   localparam int CW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = ((RW > CSR_W) ? RW : CSR_W) + 1;
   localparam logic [CW-1:0] LAST_COL = CW'(LINE_WIDTH - 1);

   function automatic logic [HW-1:0] clamp_height(input logic [CSR_W-1:0] v);
      logic [HW-1:0] w;
      w = HW'(v);
      if (w == '0) begin
         w = HW'(1);
      end else if (w > HW'(MAX_HEIGHT)) begin
         w = HW'(MAX_HEIGHT);
      end
      return w;
   endfunction

   logic [HW-1:0] heff_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          accept;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic [HW-1:0] row_p1;
   logic          last_row, last_col, col_ge1;
   logic [SUB_N-1:0] mask;

   // second stage
   logic             b_valid_ff, b_valid_in;
   pix_type          b_pixel_ff;
   logic [CW-1:0]    b_col_ff;
   logic [COORD_W-1:0] b_row_lo_ff, b_col_lo_ff;
   logic             b_row_ge1_ff, b_row_ge2_ff, b_col_ge2_ff;
   logic [SUB_N-1:0] b_mask_ff;
   logic             byp_ff, byp_in;
   logic [2*PIX_W-1:0] byp_data_ff;
   logic             b_go;

   logic [2*PIX_W-1:0] line_rd, line, line_wr;
   column_type       cur_pix;
   column_type       win_prev_ff, win_prev2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heff_ff <= clamp_height(DEF_FRAME_HEIGHT);
      end else if (csr_wr_en) begin
         heff_ff <= clamp_height(csr_wr_data);
      end
   end

   // stage A: position and classification
   always_comb begin
      accept   = req.valid && req.ready;
      cur_col  = req.frame_start ? '0 : col_ff;
      cur_row  = req.frame_start ? '0 : row_ff;
      row_p1   = HW'(cur_row) + HW'(1);
      last_row = (HW'(cur_row) == (heff_ff - HW'(1)));
      last_col = (cur_col == LAST_COL);
      col_ge1  = (cur_col != '0);
      mask[SUB_ABOVE_PREV] = (cur_row != '0) && col_ge1;
      mask[SUB_ABOVE_LAST] = (cur_row != '0) && last_col;
      mask[SUB_HERE_PREV]  = last_row && col_ge1;
      mask[SUB_HERE_LAST]  = last_row && last_col;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = (row_p1 >= heff_ff) ? '0 : RW'(row_p1);
         end else begin
            col_in = cur_col + CW'(1);
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage B: window and line store update
   always_comb begin
      line    = byp_ff ? byp_data_ff : line_rd;
      cur_pix[ROW_TOP] = line[2*PIX_W-1:PIX_W];
      cur_pix[ROW_MID] = line[PIX_W-1:0];
      cur_pix[ROW_BOT] = b_pixel_ff;
      line_wr = {line[PIX_W-1:0], b_pixel_ff};
      b_go    = b_valid_ff && ((b_mask_ff == '0) || !q_full);
      q_push  = b_valid_ff && (b_mask_ff != '0) && !q_full;
      req.ready  = !b_valid_ff || b_go;
      b_valid_in = accept ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);
      byp_in  = b_go && (b_col_ff == cur_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pixel_ff   <= req.pixel;
         b_col_ff     <= cur_col;
         b_row_lo_ff  <= COORD_W'(cur_row);
         b_col_lo_ff  <= COORD_W'(cur_col);
         b_row_ge1_ff <= (cur_row != '0);
         b_row_ge2_ff <= (cur_row > RW'(1));
         b_col_ge2_ff <= (cur_col > CW'(1));
         b_mask_ff    <= mask;
         byp_ff       <= byp_in;
         byp_data_ff  <= line_wr;
      end
      if (b_go) begin
         win_prev_ff  <= cur_pix;
         win_prev2_ff <= win_prev_ff;
      end
   end

   s2x_ram #(
      .WIDTH (2*PIX_W),
      .DEPTH (LINE_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_go),
      .wr_addr (b_col_ff),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (line_rd)
   );

   always_comb begin
      q_data.win[COL_CUR]   = cur_pix;
      q_data.win[COL_PREV]  = win_prev_ff;
      q_data.win[COL_PREV2] = win_prev2_ff;
      q_data.row     = b_row_lo_ff;
      q_data.col     = b_col_lo_ff;
      q_data.row_ge1 = b_row_ge1_ff;
      q_data.row_ge2 = b_row_ge2_ff;
      q_data.col_ge2 = b_col_ge2_ff;
      q_data.mask    = b_mask_ff;
   end

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      HW'(row_ff) < HW'(MAX_HEIGHT))
      else $error("row counter beyond maximum height");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req.frame_start) |=> (b_col_ff == '0))
      else $error("frame start did not restart at column zero");
endmodule

[src/s2x_queue.sv]
// Short transaction queue between front and back ends.
module s2x_queue #(
   parameter int DEPTH = s2x_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  s2x_pkg::s2x_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output s2x_pkg::s2x_entry_type head
);
   import s2x_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   s2x_entry_type    slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   always_comb begin
      full       = (count_ff == CNTW'(DEPTH));
      head_valid = (count_ff != '0);
      head       = slot_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue occupancy out of range");
endmodule

[src/s2x_back.sv]
// Back end: expands each queued transaction into its 2x2 blocks.
module s2x_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  s2x_pkg::s2x_entry_type head,
   output logic                   pop,
   s2x_rsp_if.source              rsp
);
   import s2x_pkg::*;

   logic [SUB_N-1:0] done_ff, done_in;
   logic [SUB_N-1:0] remaining, pick, rest;
   logic             here, at_last, is_last, load;
   column_type       col_c, col_l, col_r;
   pix_type          ctr, up, down, left, right;
   pix_type          o_tl, o_tr, o_bl, o_br;
   logic [COORD_W-1:0] o_row, o_col;

   logic               valid_ff;
   pix_type            tl_ff, tr_ff, bl_ff, br_ff;
   logic [COORD_W-1:0] row_ff, col_ff;
   logic               last_ff;

   always_comb begin
      remaining = head.mask & ~done_ff;
      pick = '0;
      priority if (remaining[SUB_ABOVE_PREV]) begin
         pick[SUB_ABOVE_PREV] = 1'b1;
      end else if (remaining[SUB_ABOVE_LAST]) begin
         pick[SUB_ABOVE_LAST] = 1'b1;
      end else if (remaining[SUB_HERE_PREV]) begin
         pick[SUB_HERE_PREV] = 1'b1;
      end else begin
         pick[SUB_HERE_LAST] = 1'b1;
      end
      rest    = remaining & ~pick;
      is_last = (rest == '0);
      here    = pick[SUB_HERE_PREV] || pick[SUB_HERE_LAST];
      at_last = pick[SUB_ABOVE_LAST] || pick[SUB_HERE_LAST];

      col_c = at_last ? head.win[COL_CUR] : head.win[COL_PREV];
      col_l = at_last ? head.win[COL_PREV] : head.win[COL_PREV2];
      col_r = head.win[COL_CUR];

      ctr   = here ? col_c[ROW_BOT] : col_c[ROW_MID];
      up    = (here ? head.row_ge1 : head.row_ge2)
              ? (here ? col_c[ROW_MID] : col_c[ROW_TOP]) : ctr;
      down  = here ? ctr : col_c[ROW_BOT];
      left  = (at_last || head.col_ge2)
              ? (here ? col_l[ROW_BOT] : col_l[ROW_MID]) : ctr;
      right = at_last ? ctr : (here ? col_r[ROW_BOT] : col_r[ROW_MID]);

      if ((up != down) && (left != right)) begin
         o_tl = (up == left)    ? up   : ctr;
         o_tr = (up == right)   ? up   : ctr;
         o_bl = (down == left)  ? down : ctr;
         o_br = (down == right) ? down : ctr;
      end else begin
         o_tl = ctr;
         o_tr = ctr;
         o_bl = ctr;
         o_br = ctr;
      end
      o_row = here ? head.row : head.row - COORD_W'(1);
      o_col = at_last ? head.col : head.col - COORD_W'(1);

      load    = head_valid && (!valid_ff || rsp.ready);
      pop     = load && is_last;
      done_in = done_ff;
      if (load) begin
         done_in = is_last ? '0 : (done_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tl_ff   <= o_tl;
         tr_ff   <= o_tr;
         bl_ff   <= o_bl;
         br_ff   <= o_br;
         row_ff  <= o_row;
         col_ff  <= o_col;
         last_ff <= is_last;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.top_left     = tl_ff;
   assign rsp.top_right    = tr_ff;
   assign rsp.bottom_left  = bl_ff;
   assign rsp.bottom_right = br_ff;
   assign rsp.src_row      = row_ff;
   assign rsp.src_column   = col_ff;
   assign rsp.run_last     = last_ff;

   a_work_left: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (remaining != '0))
      else $error("queued transaction with no blocks left");
endmodule

[src/scale2x_upscaler_top.sv]
// Top level of the streaming Scale2x 2x pixel upscaler.
//
//   port        dir   handshake        carries
//   req_chan    in    valid/ready      pixel, frame_start
//   rsp_chan    out   valid/ready      2x2 block, src_column, src_row, run_last
//   csr_wr_*    in    write enable     frame_height
//
// One pixel taken per clock unless the queue is full; each gives 0 to 4 blocks.
// One block leaves per clock while rsp_chan is ready.
// Line store: one RAM of LINE_WIDTH words, one read and one write per pixel.
// Reset clears position counters; line store needs no clearing pass.
// Output register and transaction queue let input keep flowing while rsp stalls.
module scale2x_upscaler_top #(
   parameter int LINE_WIDTH  = s2x_pkg::DEF_LINE_WIDTH,
   parameter int MAX_HEIGHT  = s2x_pkg::DEF_MAX_HEIGHT,
   parameter int QUEUE_DEPTH = s2x_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [s2x_pkg::CSR_W-1:0] csr_wr_data,
   s2x_req_if.sink                   req_chan,
   s2x_rsp_if.source                 rsp_chan
);
   import s2x_pkg::*;

   logic          q_push, q_full, q_pop, q_head_valid;
   s2x_entry_type q_push_data, q_head;

   s2x_front #(
      .LINE_WIDTH (LINE_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   s2x_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   s2x_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );
endmodule
